// ===== sv/dfa_pkg.sv =====
// Shared types and constants for the table-driven DFA recognizer.
// No dependencies; imported by dfa_clear, the top level and the testbench.
package dfa_pkg;

  localparam int NUM_STATES_DEF  = 64;
  localparam int SYMBOL_BITS_DEF = 8;
  localparam int STATE_W         = 6;
  localparam int SYM_W           = 8;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_FLAG   = 2'd1,
    KIND_SYMBOL = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [STATE_W-1:0] state_index;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] next_state;
    logic               flag_value;
  } item_t;

  typedef struct packed {
    logic accepted;
    logic hit_dead_end;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] target;
  } trans_entry_t;

  localparam int ENTRY_W = $bits(trans_entry_t);

  typedef enum logic {
    CLR_SWEEP = 1'b0,
    CLR_DONE  = 1'b1
  } clr_state_t;

endpackage

// ===== sv/dfa_mem.sv =====
// Single-port-write, single-port-read synchronous RAM, registered read data.
// Standalone; used for the transition table and the accepting flags.
module dfa_mem #(
  parameter int  WIDTH = 1,
  parameter int  DEPTH = 2,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/dfa_clear.sv =====
// Post-reset clearing sweep: walks every table address once.
// Depends on dfa_pkg for the sweep state type.
module dfa_clear #(
  parameter int  DEPTH = 4,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  output logic          busy,
  output logic [AW-1:0] addr
);
  import dfa_pkg::*;

  clr_state_t    state, state_next;
  logic [AW-1:0] addr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLR_SWEEP;
      addr  <= '0;
    end else begin
      state <= state_next;
      addr  <= addr_next;
    end
  end

  always_comb begin
    state_next = state;
    addr_next  = addr;
    busy       = 1'b0;
    case (state)
      CLR_SWEEP: begin
        busy = 1'b1;
        if (addr == AW'(DEPTH - 1)) begin
          state_next = CLR_DONE;
        end else begin
          addr_next = addr + 1'b1;
        end
      end
      CLR_DONE: ;
      default: state_next = CLR_DONE;
    endcase
  end

endmodule

// ===== sv/dfa_table_string_recognizer.sv =====
// Table-driven DFA string recognizer, top level.
// Depends on dfa_pkg, dfa_mem and dfa_clear.
//
// Usage:
//   item channel (item_valid / item_stall / item): load items write a
//   transition entry or an accepting flag, symbol items advance the current
//   state, an end-of-string item produces one result and restarts at the
//   start state.
//   result channel (result_valid / result_stall / result): one item per
//   end of string.
//   start channel (start_valid / start_ready / start_state): start state,
//   always ready, used at the next end of string.
// Throughput: one item per cycle while item_stall is low. The transition read
// data feeds the next lookup address directly, so consecutive symbols chain
// through the table RAM's registered read.
// A result passes through the registered flag read and the s1 stage, and is
// then written into the result queue, which offers it on the result channel.
// A two-entry result queue keeps items flowing while result_stall is high;
// item_stall rises during the clearing sweep and when that queue would fill.
// Reset: a clearing sweep over all NUM_STATES * 2**SYMBOL_BITS table addresses
// (16384 by default) zeroes the table and flags; item_stall is high throughout.
module dfa_table_string_recognizer #(
  parameter int NUM_STATES  = dfa_pkg::NUM_STATES_DEF,
  parameter int SYMBOL_BITS = dfa_pkg::SYMBOL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  dfa_pkg::item_t               item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output dfa_pkg::result_t             result,
  input  logic                         start_valid,
  output logic                         start_ready,
  input  logic [dfa_pkg::STATE_W-1:0]  start_state
);
  import dfa_pkg::*;

  localparam int SBITS  = $clog2(NUM_STATES);
  localparam int ADDR_W = SBITS + SYMBOL_BITS;
  localparam int DEPTH  = NUM_STATES * (1 << SYMBOL_BITS);

  logic [STATE_W-1:0] start_cfg;
  logic [STATE_W-1:0] cur_state, cur_state_next;
  logic               dead, dead_next;
  logic               s1_lookup, s1_eos, s1_dead, s1_inrange;

  logic [STATE_W-1:0] eff_state;
  logic               eff_dead, eff_ok, idx_ok, sym_ok;
  logic [SBITS+STATE_W-1:0] eff_ext, idx_ext;

  logic               item_acc, tbl_re, tbl_we, flag_re, flag_we, sym_dead;
  logic               clr_busy;
  logic [ADDR_W-1:0]  clr_addr;

  logic               tw_en, fw_en;
  logic [ADDR_W-1:0]  tw_addr, tr_addr;
  logic [ENTRY_W-1:0] tw_data, tr_data;
  logic [SBITS-1:0]   fw_addr, fr_addr;
  logic [0:0]         fw_data, fr_data;
  trans_entry_t       tbl_wr, tbl_rd;

  result_t            res_new, rq0, rq1;
  logic [1:0]         rq_count;
  logic               pop;

  dfa_clear #(.DEPTH(DEPTH)) u_clear (
    .clk  (clk),
    .rst  (rst),
    .busy (clr_busy),
    .addr (clr_addr)
  );

  dfa_mem #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .we    (tw_en),
    .waddr (tw_addr),
    .wdata (tw_data),
    .re    (tbl_re),
    .raddr (tr_addr),
    .rdata (tr_data)
  );

  dfa_mem #(.WIDTH(1), .DEPTH(NUM_STATES)) u_flags (
    .clk   (clk),
    .we    (fw_en),
    .waddr (fw_addr),
    .wdata (fw_data),
    .re    (flag_re),
    .raddr (fr_addr),
    .rdata (fr_data)
  );

  assign tbl_rd = trans_entry_t'(tr_data);

  // state as seen by the item in this cycle: forwarded from the table read
  always_comb begin
    eff_state = cur_state;
    eff_dead  = dead;
    if (s1_lookup) begin
      if (tbl_rd.valid) begin
        eff_state = tbl_rd.target;
      end else begin
        eff_dead = 1'b1;
      end
    end
  end

  assign eff_ok  = 32'(eff_state) < NUM_STATES;
  assign idx_ok  = 32'(item.state_index) < NUM_STATES;
  assign sym_ok  = 32'(item.symbol) < (32'(1) << SYMBOL_BITS);
  assign eff_ext = {{SBITS{1'b0}}, eff_state};
  assign idx_ext = {{SBITS{1'b0}}, item.state_index};

  assign item_acc = item_valid && !item_stall;

  always_comb begin
    tbl_re   = 1'b0;
    tbl_we   = 1'b0;
    flag_re  = 1'b0;
    flag_we  = 1'b0;
    sym_dead = 1'b0;
    if (item_acc) begin
      case (item.kind)
        KIND_WRITE:  tbl_we = idx_ok && sym_ok;
        KIND_FLAG:   flag_we = idx_ok;
        KIND_SYMBOL: begin
          if (!eff_dead) begin
            if (eff_ok && sym_ok) begin
              tbl_re = 1'b1;
            end else begin
              sym_dead = 1'b1;
            end
          end
        end
        KIND_END:    flag_re = eff_ok;
        default: ;
      endcase
    end
  end

  assign tr_addr       = {eff_ext[SBITS-1:0], item.symbol[SYMBOL_BITS-1:0]};
  assign fr_addr       = eff_ext[SBITS-1:0];
  assign tbl_wr.valid  = item.flag_value;
  assign tbl_wr.target = item.next_state;

  // clearing sweep owns the write ports until it finishes
  always_comb begin
    if (clr_busy) begin
      tw_en   = 1'b1;
      tw_addr = clr_addr;
      tw_data = '0;
      fw_en   = 32'(clr_addr) < NUM_STATES;
      fw_addr = clr_addr[SBITS-1:0];
      fw_data = 1'b0;
    end else begin
      tw_en   = tbl_we;
      tw_addr = {idx_ext[SBITS-1:0], item.symbol[SYMBOL_BITS-1:0]};
      tw_data = tbl_wr;
      fw_en   = flag_we;
      fw_addr = idx_ext[SBITS-1:0];
      fw_data = item.flag_value;
    end
  end

  always_comb begin
    cur_state_next = eff_state;
    dead_next      = eff_dead || sym_dead;
    if (item_acc && item.kind == KIND_END) begin
      cur_state_next = start_cfg;
      dead_next      = 1'b0;
    end
  end

  assign start_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_cfg <= '0;
      cur_state <= '0;
      dead      <= 1'b0;
      s1_lookup <= 1'b0;
      s1_eos    <= 1'b0;
    end else begin
      if (start_valid && start_ready) begin
        start_cfg <= start_state;
      end
      cur_state <= cur_state_next;
      dead      <= dead_next;
      s1_lookup <= tbl_re;
      s1_eos    <= item_acc && item.kind == KIND_END;
    end
    s1_dead    <= eff_dead;
    s1_inrange <= eff_ok;
  end

  assign res_new.accepted     = !s1_dead && s1_inrange && fr_data[0];
  assign res_new.hit_dead_end = s1_dead;

  // two-entry result queue
  assign result_valid = rq_count != 2'd0;
  assign result       = rq0;
  assign pop          = result_valid && !result_stall;
  assign item_stall   = clr_busy || ((3'(rq_count) + 3'(s1_eos) - 3'(pop)) >= 3'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_count <= 2'd0;
    end else begin
      rq_count <= rq_count + 2'(s1_eos) - 2'(pop);
    end
    case ({s1_eos, pop})
      2'b10: begin
        if (rq_count == 2'd0) begin
          rq0 <= res_new;
        end else begin
          rq1 <= res_new;
        end
      end
      2'b01: rq0 <= rq1;
      2'b11: begin
        if (rq_count == 2'd1) begin
          rq0 <= res_new;
        end else begin
          rq0 <= rq1;
          rq1 <= res_new;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    !(s1_eos && rq_count == 2'd2))
    else $error("result queue overflow");

  a_lookup_live: assert property (@(posedge clk) disable iff (rst)
    s1_lookup |-> !dead)
    else $error("table lookup issued while dead");

  a_end_restart: assert property (@(posedge clk) disable iff (rst)
    (item_acc && item.kind == KIND_END) |=> (!dead && cur_state == $past(start_cfg)))
    else $error("end of string did not restart at start state");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> (!s1_lookup && !s1_eos && !result_valid))
    else $error("activity during clearing sweep");
`endif

endmodule

// ===== tb/dfa_table_string_recognizer_test.sv =====
// Self-checking testbench for dfa_table_string_recognizer: loads random automata,
// runs strings through them and compares each end-of-string verdict to a predictor.
// Depends on dfa_pkg and the recognizer RTL.
`timescale 1ns / 100ps

module dfa_table_string_recognizer_test;
  import dfa_pkg::*;

  localparam int NSYM        = 1 << SYMBOL_BITS_DEF;
  localparam int QUIET_LIMIT = 60000;

  class verdict_board;
    bit                 trans_ok [NUM_STATES_DEF][NSYM];
    bit [STATE_W-1:0]   trans_to [NUM_STATES_DEF][NSYM];
    bit                 accepting [NUM_STATES_DEF];
    bit [STATE_W-1:0]   cur_state;
    bit [STATE_W-1:0]   start_reg;
    bit                 dead;
    result_t            pending[$];
    int                 errors;

    function void note_item(item_t it);
      result_t v;
      case (it.kind)
        KIND_WRITE: begin
          trans_ok[it.state_index][it.symbol] = it.flag_value;
          trans_to[it.state_index][it.symbol] = it.next_state;
        end
        KIND_FLAG: begin
          accepting[it.state_index] = it.flag_value;
        end
        KIND_SYMBOL: begin
          if (!dead) begin
            if (trans_ok[cur_state][it.symbol]) cur_state = trans_to[cur_state][it.symbol];
            else dead = 1'b1;
          end
        end
        default: begin
          v.accepted     = !dead && accepting[cur_state];
          v.hit_dead_end = dead;
          pending.insert(pending.size(), v);
          cur_state = start_reg;
          dead      = 1'b0;
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result item: accepted %0b hit_dead_end %0b",
               got.accepted, got.hit_dead_end);
        errors++;
        return;
      end
      want = pending[0];
      pending.delete(0);
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
        errors++;
      end
      if (got.hit_dead_end !== want.hit_dead_end) begin
        $error("hit_dead_end: expected %0b, got %0b", want.hit_dead_end, got.hit_dead_end);
        errors++;
      end
    endfunction

    function void set_start(bit [STATE_W-1:0] v);
      start_reg = v;
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               item_valid;
  logic               item_stall;
  item_t              item;
  logic               result_valid;
  logic               result_stall;
  result_t            result;
  logic               start_valid;
  logic               start_ready;
  logic [STATE_W-1:0] start_state;

  verdict_board board = new;
  int src_idle_pct = 34;
  int rcv_idle_pct = 34;
  int hold_len     = 0;
  int quiet_cycles = 0;

  dfa_table_string_recognizer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .start_valid  (start_valid),
    .start_ready  (start_ready),
    .start_state  (start_state)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        result_stall = 1'b1;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      result_stall = ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) board.check_result(result);
      if (item_valid && !item_stall) board.note_item(item);
      if (start_valid && start_ready) board.set_start(start_state);
      if ((result_valid && !result_stall) || (item_valid && !item_stall) ||
          (start_valid && start_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("dfa_table_string_recognizer_test NOT OK");
        $finish;
      end
    end
  end

  task automatic push_item(input kind_t k, input int s, input int sym, input int t,
                           input int f);
    while ($urandom_range(99) < src_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    item       = '{kind: k, state_index: STATE_W'(s), symbol: SYM_W'(sym),
                   next_state: STATE_W'(t), flag_value: f[0]};
    do @(posedge clk); while (item_stall);
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  task automatic write_start(input logic [STATE_W-1:0] v);
    start_valid = 1'b1;
    start_state = v;
    do @(posedge clk); while (!start_ready);
    @(negedge clk);
    start_valid = 1'b0;
  endtask

  // wait out all verdicts, then the pipeline
  task automatic settle();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic random_phase(input logic [STATE_W-1:0] start, input int n_items);
    int states[8];
    int alpha[4];
    int nst, nsym, count, len;
    nst   = $urandom_range(8, 2);
    nsym  = $urandom_range(4, 1);
    count = 0;
    states[0] = int'(start);
    for (int i = 1; i < nst; i++) states[i] = $urandom_range(NUM_STATES_DEF - 1);
    for (int j = 0; j < nsym; j++) alpha[j] = $urandom_range(NSYM - 1);
    write_start(start);
    for (int i = 0; i < nst; i++) begin
      for (int j = 0; j < nsym; j++) begin
        push_item(KIND_WRITE, states[i], alpha[j], states[$urandom_range(nst - 1)],
                  ($urandom_range(9) != 0) ? 1 : 0);
        count++;
      end
      push_item(KIND_FLAG, states[i], $urandom, $urandom, $urandom_range(1));
      count++;
    end
    while (count < n_items) begin
      if ($urandom_range(99) < 8) begin
        push_item(kind_t'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
        count++;
      end else begin
        len = $urandom_range(10);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(24) == 0)
            push_item(KIND_WRITE, states[$urandom_range(nst - 1)], alpha[$urandom_range(nsym - 1)],
                      states[$urandom_range(nst - 1)], ($urandom_range(3) != 0) ? 1 : 0);
          else if ($urandom_range(19) == 0)
            push_item(KIND_SYMBOL, $urandom, $urandom, $urandom, $urandom);
          else
            push_item(KIND_SYMBOL, $urandom, alpha[$urandom_range(nsym - 1)], $urandom, $urandom);
          count++;
        end
        push_item(KIND_END, $urandom, $urandom, $urandom, $urandom);
        count++;
      end
    end
    push_item(KIND_END, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    logic [STATE_W-1:0] st;
    rst         = 1'b1;
    item_valid  = 1'b0;
    item        = '0;
    start_valid = 1'b0;
    start_state = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed: empty strings, extremes, dead paths, invalidation, loads mid-string
    push_item(KIND_END,    0,   0,  0, 0);
    push_item(KIND_FLAG,   0,   0,  0, 1);
    push_item(KIND_END,    0,   0,  0, 0);
    push_item(KIND_WRITE,  0, 255, 63, 1);
    push_item(KIND_FLAG,  63,   0,  0, 1);
    push_item(KIND_SYMBOL, 0, 255,  0, 0);
    push_item(KIND_END,    0,   0,  0, 0);
    push_item(KIND_SYMBOL, 0,   0,  0, 0);
    push_item(KIND_SYMBOL, 0, 255,  0, 0);
    push_item(KIND_END,   63, 255, 63, 1);
    push_item(KIND_WRITE, 63,   0,  0, 1);
    push_item(KIND_SYMBOL, 0, 255,  0, 0);
    push_item(KIND_SYMBOL, 0,   0,  0, 0);
    push_item(KIND_END,    0,   0,  0, 0);
    push_item(KIND_WRITE, 63,   0,  0, 0);
    push_item(KIND_SYMBOL, 0, 255,  0, 0);
    push_item(KIND_SYMBOL, 0,   0,  0, 0);
    push_item(KIND_END,    0,   0,  0, 0);
    push_item(KIND_SYMBOL, 0, 255,  0, 0);
    push_item(KIND_WRITE, 63,   0,  0, 1);
    push_item(KIND_SYMBOL, 0,   0,  0, 0);
    push_item(KIND_FLAG,  63,   0,  0, 0);
    push_item(KIND_FLAG,   0,   0,  0, 0);
    push_item(KIND_END,    0,   0,  0, 0);
    push_item(KIND_SYMBOL, 0, 255,  0, 0);
    push_item(KIND_END,    0,   0,  0, 0);
    settle();

    for (int p = 0; p < 10; p++) begin
      if (p == 0) st = '1;
      else if (p == 1) st = '0;
      else st = STATE_W'($urandom_range(NUM_STATES_DEF - 1));
      src_idle_pct = (p == 3 || p == 5) ? 0 : 34;
      rcv_idle_pct = (p == 3) ? 0 : 34;
      if (p == 5) hold_len = 300;
      random_phase(st, 165);
      settle();
    end

    if (board.errors == 0) begin
      $display("dfa_table_string_recognizer_test OK");
    end else begin
      $display("dfa_table_string_recognizer_test NOT OK");
    end
    $finish;
  end

endmodule
